// File: hw/rtl/cvl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvl_pkg
// Shared types and constants of the 3x3 luma convolution filter.
// ----------------------------------------------------------------------------
package cvl_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned DIM_W      = 12;
  localparam int unsigned DIVISOR_W  = 15;
  localparam int unsigned COORD_W    = 11;
  localparam int unsigned NUM_TAPS   = 9;
  localparam int unsigned TAP_IDX_W  = 4;
  localparam int unsigned ACC_W      = 20;
  localparam int unsigned MAG_W      = 19;
  localparam int unsigned DIV_CNT_W  = 5;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAPS_LOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_LAST  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIVISOR   = 3'd4;

  localparam logic [DIM_W-1:0]      WIDTH_RST    = 12'd640;
  localparam logic [DIM_W-1:0]      HEIGHT_RST   = 12'd480;
  localparam logic [63:0]           TAPS_RST     = 64'h0000_0001_0000_0000;
  localparam logic [7:0]            TAP_LAST_RST = 8'h00;
  localparam logic [DIVISOR_W-1:0]  DIVISOR_RST  = 15'd1;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hff;
  localparam logic [7:0] GREY_MAX     = 8'd255;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MAC,
    ST_DIV,
    ST_PUSH
  } state_e;

endpackage

// File: hw/rtl/cvl_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvl_in_if
// Luma sample channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface cvl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma;
  logic       frame_start;

  modport source (output valid, output luma, output frame_start, input ready);
  modport sink   (input valid, input luma, input frame_start, output ready);
endinterface

// File: hw/rtl/cvl_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvl_out_if
// Filtered pixel channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface cvl_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_argb;
  logic [10:0] out_row;
  logic [10:0] out_col;
  logic        frame_last;

  modport source (output valid, output pixel_argb, output out_row, output out_col,
                  output frame_last, input ready);
  modport sink   (input valid, input pixel_argb, input out_row, input out_col,
                  input frame_last, output ready);
endinterface

// File: hw/rtl/convolution_3x3_luma_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// convolution_3x3_luma_filter
// 3x3 convolution over a raster luma stream, divided, clamped, grey ARGB out.
// ----------------------------------------------------------------------------
//  channel   direction  handshake     payload
//  in_if     sink       valid/ready   luma, frame_start
//  out_if    source     valid/ready   pixel_argb, out_row, out_col, frame_last
//  cfg       write      cfg_we_i      cfg_idx_i, cfg_wdata_i
//
//  Border item: accept, then line memory read/write-back. Interior item: accept,
//  read, one tap product per step on the single tap multiplier, bit-serial
//  divide, push; non-positive sums skip the divider. Reset clears state,
//  counters and window and loads configuration defaults, not the line memory.
//  A full output register stalls the pipe in the push state.
// ----------------------------------------------------------------------------
module convolution_3x3_luma_filter #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 2048
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [cvl_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [cvl_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  cvl_in_if.sink                            in_if,
  cvl_out_if.source                         out_if
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);

  // configuration
  logic [cvl_pkg::DIM_W-1:0]     width_q, height_q;
  logic [63:0]                   taps_q;
  logic [7:0]                    tap_last_q;
  logic [cvl_pkg::DIVISOR_W-1:0] divisor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= cvl_pkg::WIDTH_RST;
      height_q   <= cvl_pkg::HEIGHT_RST;
      taps_q     <= cvl_pkg::TAPS_RST;
      tap_last_q <= cvl_pkg::TAP_LAST_RST;
      divisor_q  <= cvl_pkg::DIVISOR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cvl_pkg::REG_WIDTH:    width_q    <= cfg_wdata_i[cvl_pkg::DIM_W-1:0];
        cvl_pkg::REG_HEIGHT:   height_q   <= cfg_wdata_i[cvl_pkg::DIM_W-1:0];
        cvl_pkg::REG_TAPS_LOW: taps_q     <= cfg_wdata_i;
        cvl_pkg::REG_TAP_LAST: tap_last_q <= cfg_wdata_i[7:0];
        cvl_pkg::REG_DIVISOR:  divisor_q  <= cfg_wdata_i[cvl_pkg::DIVISOR_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped geometry and divisor
  logic [CW:0]                   w_c;
  logic [RW:0]                   h_c;
  logic [cvl_pkg::DIVISOR_W-1:0] div_c;

  always_comb begin
    if (32'(width_q) < 32'd3)           w_c = (CW+1)'(3);
    else if (32'(width_q) > MAX_WIDTH)  w_c = (CW+1)'(MAX_WIDTH);
    else                                w_c = (CW+1)'(width_q);
    if (32'(height_q) < 32'd3)          h_c = (RW+1)'(3);
    else if (32'(height_q) > MAX_HEIGHT) h_c = (RW+1)'(MAX_HEIGHT);
    else                                h_c = (RW+1)'(height_q);
    div_c = (divisor_q == '0) ? cvl_pkg::DIVISOR_W'(1) : divisor_q;
  end

  // state
  cvl_pkg::state_e state_q, state_d;
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] c_q, c_d;
  logic [RW-1:0] r_q, r_d;
  logic [7:0]    cur_q, cur_d;
  logic          prod_q, prod_d;
  logic          last_q, last_d;
  logic [7:0]    win_q [6];
  logic [7:0]    px_q [cvl_pkg::NUM_TAPS];
  logic [15:0]   rd_q;
  logic [cvl_pkg::TAP_IDX_W-1:0] k_q, k_d;
  logic signed [cvl_pkg::ACC_W-1:0] acc_q, acc_d;
  logic [7:0]    g_q, g_d;
  logic          out_valid_q, out_valid_d;
  logic [31:0]   argb_q;
  logic [cvl_pkg::COORD_W-1:0] orow_q, ocol_q;
  logic          olast_q;
  logic          load_out;

  logic [15:0]   mem [MAX_WIDTH];

  logic          in_acc;
  logic [CW:0]   c_pre, c_inc;
  logic [RW:0]   r_pre, r_inc;
  logic [7:0]    tap_sel;
  logic signed [16:0] prod;
  logic          div_start, div_done;
  logic [cvl_pkg::MAG_W-1:0] quot;

  assign in_if.ready = (state_q == cvl_pkg::ST_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;

  always_comb begin
    tap_sel = (k_q < cvl_pkg::TAP_IDX_W'(8)) ? taps_q[k_q[2:0]*8 +: 8] : tap_last_q;
    prod    = $signed(tap_sel) * $signed({1'b0, px_q[k_q]});
  end

  always_comb begin
    state_d     = state_q;
    col_d       = col_q;
    row_d       = row_q;
    c_d         = c_q;
    r_d         = r_q;
    cur_d       = cur_q;
    prod_d      = prod_q;
    last_d      = last_q;
    k_d         = k_q;
    acc_d       = acc_q;
    g_d         = g_q;
    div_start   = 1'b0;
    load_out    = 1'b0;
    out_valid_d = out_valid_q && !out_if.ready;
    c_pre       = '0;
    r_pre       = '0;
    c_inc       = '0;
    r_inc       = '0;
    unique case (state_q)
      cvl_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_if.frame_start) begin
            c_pre = '0;
            r_pre = '0;
          end else begin
            c_pre = ({1'b0, col_q} >= w_c) ? '0 : {1'b0, col_q};
            r_pre = ({1'b0, col_q} >= w_c) ? {1'b0, row_q} + 1'b1 : {1'b0, row_q};
            if (r_pre >= h_c) r_pre = '0;
          end
          c_inc = c_pre + 1'b1;
          r_inc = r_pre + 1'b1;
          if (c_inc >= w_c) begin
            col_d = '0;
            row_d = (r_inc >= h_c) ? '0 : r_inc[RW-1:0];
          end else begin
            col_d = c_inc[CW-1:0];
            row_d = r_pre[RW-1:0];
          end
          c_d     = c_pre[CW-1:0];
          r_d     = r_pre[RW-1:0];
          cur_d   = in_if.luma;
          prod_d  = (r_pre >= (RW+1)'(2)) && (c_pre >= (CW+1)'(2));
          last_d  = (r_inc == h_c) && (c_inc == w_c);
          state_d = cvl_pkg::ST_READ;
        end
      end
      cvl_pkg::ST_READ: begin
        k_d     = '0;
        acc_d   = '0;
        state_d = prod_q ? cvl_pkg::ST_MAC : cvl_pkg::ST_IDLE;
      end
      cvl_pkg::ST_MAC: begin
        acc_d = acc_q + prod;
        k_d   = k_q + 1'b1;
        if (k_q == cvl_pkg::TAP_IDX_W'(cvl_pkg::NUM_TAPS - 1)) begin
          if (acc_d > 0) begin
            div_start = 1'b1;
            state_d   = cvl_pkg::ST_DIV;
          end else begin
            g_d     = '0;
            state_d = cvl_pkg::ST_PUSH;
          end
        end
      end
      cvl_pkg::ST_DIV: begin
        if (div_done) begin
          g_d     = (quot > cvl_pkg::MAG_W'(cvl_pkg::GREY_MAX)) ? cvl_pkg::GREY_MAX : quot[7:0];
          state_d = cvl_pkg::ST_PUSH;
        end
      end
      cvl_pkg::ST_PUSH: begin
        if (!out_valid_q || out_if.ready) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = cvl_pkg::ST_IDLE;
        end
      end
      default: state_d = cvl_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cvl_pkg::ST_IDLE;
      col_q       <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 6; i++) win_q[i] <= '0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      row_q       <= row_d;
      out_valid_q <= out_valid_d;
      if (state_q == cvl_pkg::ST_READ) begin
        win_q[0] <= win_q[3];
        win_q[1] <= win_q[4];
        win_q[2] <= win_q[5];
        win_q[3] <= rd_q[15:8];
        win_q[4] <= rd_q[7:0];
        win_q[5] <= cur_q;
      end
    end
  end

  // line memory: entry holds {row above middle, middle row}
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_q <= mem[c_pre[CW-1:0]];
    end
    if (state_q == cvl_pkg::ST_READ) begin
      mem[c_q] <= {rd_q[7:0], cur_q};
    end
  end

  always_ff @(posedge clk_i) begin
    c_q    <= c_d;
    r_q    <= r_d;
    cur_q  <= cur_d;
    prod_q <= prod_d;
    last_q <= last_d;
    k_q    <= k_d;
    acc_q  <= acc_d;
    g_q    <= g_d;
    if (state_q == cvl_pkg::ST_READ) begin
      px_q[0] <= win_q[0];
      px_q[1] <= win_q[3];
      px_q[2] <= rd_q[15:8];
      px_q[3] <= win_q[1];
      px_q[4] <= win_q[4];
      px_q[5] <= rd_q[7:0];
      px_q[6] <= win_q[2];
      px_q[7] <= win_q[5];
      px_q[8] <= cur_q;
    end
    if (load_out) begin
      argb_q  <= {cvl_pkg::ALPHA_OPAQUE, g_q, g_q, g_q};
      orow_q  <= cvl_pkg::COORD_W'(r_q - 1'b1);
      ocol_q  <= cvl_pkg::COORD_W'(c_q - 1'b1);
      olast_q <= last_q;
    end
  end

  cvl_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc_d[cvl_pkg::MAG_W-1:0]),
    .divisor_i  (div_c),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  assign out_if.valid      = out_valid_q;
  assign out_if.pixel_argb = argb_q;
  assign out_if.out_row    = orow_q;
  assign out_if.out_col    = ocol_q;
  assign out_if.frame_last = olast_q;

endmodule

// File: hw/rtl/cvl_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvl_div
// Restoring divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module cvl_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [cvl_pkg::MAG_W-1:0]          dividend_i,
  input  logic [cvl_pkg::DIVISOR_W-1:0]      divisor_i,
  output logic                               done_o,
  output logic [cvl_pkg::MAG_W-1:0]          quot_o
);

  logic [cvl_pkg::MAG_W-1:0]     quot_q, quot_d;
  logic [cvl_pkg::DIVISOR_W-1:0] rem_q, rem_d;
  logic [cvl_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [cvl_pkg::DIVISOR_W:0]   rem_sh;
  logic [cvl_pkg::DIVISOR_W:0]   rem_sub;
  logic                          ge;

  always_comb begin
    rem_sh  = {rem_q, quot_q[cvl_pkg::MAG_W-1]};
    ge      = rem_sh >= {1'b0, divisor_i};
    rem_sub = rem_sh - {1'b0, divisor_i};
    quot_d  = quot_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      cnt_d  = cvl_pkg::DIV_CNT_W'(cvl_pkg::MAG_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quot_d = {quot_q[cvl_pkg::MAG_W-2:0], ge};
      rem_d  = ge ? rem_sub[cvl_pkg::DIVISOR_W-1:0] : rem_sh[cvl_pkg::DIVISOR_W-1:0];
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == cvl_pkg::DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// File: verif/convolution_3x3_luma_filter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// convolution_3x3_luma_filter_tb
// Streams luma frames through the 3x3 filter and checks every filtered pixel
// against a cycle-free predictor of the line stores, window and arithmetic,
// across several frame geometries, kernels and divisors, with random stalls.
// ----------------------------------------------------------------------------
module convolution_3x3_luma_filter_tb;

  localparam int unsigned MAXW = 2048;
  localparam int unsigned MAXH = 2048;
  localparam int unsigned STALL_LIMIT = 5000;

  typedef struct packed {
    logic [31:0] argb;
    logic [10:0] row;
    logic [10:0] col;
    logic        last;
  } grey_pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [cvl_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [cvl_pkg::CFG_DATA_W-1:0] cfg_wdata_i = '0;

  cvl_in_if in_ch();
  cvl_out_if out_ch();

  convolution_3x3_luma_filter #(.MAX_WIDTH(MAXW), .MAX_HEIGHT(MAXH)) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (in_ch),
    .out_if      (out_ch)
  );

  // predictor state
  logic [cvl_pkg::DIM_W-1:0] width_q = cvl_pkg::WIDTH_RST;
  logic [cvl_pkg::DIM_W-1:0] height_q = cvl_pkg::HEIGHT_RST;
  logic [63:0] taps_low_q = cvl_pkg::TAPS_RST;
  logic [7:0] tap_last_q = cvl_pkg::TAP_LAST_RST;
  logic [cvl_pkg::DIVISOR_W-1:0] divisor_q = cvl_pkg::DIVISOR_RST;
  logic [7:0] line_mem [0:2*MAXW-1];
  logic [7:0] win_q [0:5];
  int unsigned col_q = 0;
  int unsigned row_q = 0;

  grey_pixel_t pending_pixels[$];
  int unsigned errors = 0;
  int unsigned pixels_sent = 0;
  int unsigned stall_cycles = 0;
  bit no_idle = 1'b0;

  always #2 clk_i = ~clk_i;

  initial begin
    for (int i = 0; i < 2 * MAXW; i++) line_mem[i] = '0;
    for (int i = 0; i < 6; i++) win_q[i] = '0;
    in_ch.valid = 1'b0;
    in_ch.luma = '0;
    in_ch.frame_start = 1'b0;
    out_ch.ready = 1'b0;
  end

  function automatic int unsigned clamp_dim(logic [cvl_pkg::DIM_W-1:0] v, int unsigned maxv);
    if (v < 3) return 3;
    if (v > maxv) return maxv;
    return 32'(v);
  endfunction

  function automatic void predict_pixel(logic [7:0] luma, logic fs);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int unsigned r;
    logic [7:0] top;
    logic [7:0] mid;
    logic [7:0] px [0:8];
    int sum;
    int g;
    int d;
    int tp;
    grey_pixel_t p;
    w = clamp_dim(width_q, MAXW);
    h = clamp_dim(height_q, MAXH);
    if (fs) begin
      col_q = 0;
      row_q = 0;
    end else begin
      if (col_q >= w) begin
        col_q = 0;
        row_q++;
      end
      if (row_q >= h) row_q = 0;
    end
    c = col_q;
    r = row_q;
    top = line_mem[MAXW + c];
    mid = line_mem[c];
    if (r >= 2 && c >= 2) begin
      px = '{win_q[0], win_q[3], top, win_q[1], win_q[4], mid, win_q[2], win_q[5], luma};
      sum = 0;
      for (int n = 0; n < 9; n++) begin
        tp = (n < 8) ? int'($signed(taps_low_q[8*n +: 8])) : int'($signed(tap_last_q));
        sum += tp * int'(px[n]);
      end
      d = (divisor_q == 0) ? 1 : int'(divisor_q);
      g = sum / d;
      if (g > 255) g = 255;
      if (g < 0) g = 0;
      p.argb = {cvl_pkg::ALPHA_OPAQUE, g[7:0], g[7:0], g[7:0]};
      p.row = 11'(r - 1);
      p.col = 11'(c - 1);
      p.last = (r == h - 1 && c == w - 1);
      pending_pixels.push_back(p);
    end
    line_mem[MAXW + c] = mid;
    line_mem[c] = luma;
    win_q[0] = win_q[3];
    win_q[1] = win_q[4];
    win_q[2] = win_q[5];
    win_q[3] = top;
    win_q[4] = mid;
    win_q[5] = luma;
    if (c + 1 >= w) begin
      col_q = 0;
      row_q = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_q = c + 1;
    end
  endfunction

  // entered and left just after a falling edge
  task automatic send_pixel(logic [7:0] luma, logic fs);
    if (!no_idle) begin
      while ($urandom_range(99) < 23) begin
        in_ch.valid <= 1'b0;
        @(negedge clk_i);
      end
    end
    in_ch.valid <= 1'b1;
    in_ch.luma <= luma;
    in_ch.frame_start <= fs;
    do @(posedge clk_i); while (!in_ch.ready);
    predict_pixel(luma, fs);
    pixels_sent++;
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [cvl_pkg::CFG_IDX_W-1:0] idx, logic [63:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      cvl_pkg::REG_WIDTH: width_q = data[cvl_pkg::DIM_W-1:0];
      cvl_pkg::REG_HEIGHT: height_q = data[cvl_pkg::DIM_W-1:0];
      cvl_pkg::REG_TAPS_LOW: taps_low_q = data;
      cvl_pkg::REG_TAP_LAST: tap_last_q = data[7:0];
      cvl_pkg::REG_DIVISOR: divisor_q = data[cvl_pkg::DIVISOR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic drain;
    in_ch.valid <= 1'b0;
    wait (pending_pixels.size() == 0);
    repeat (60) @(negedge clk_i);
  endtask

  task automatic set_kernel(logic [63:0] lo, logic [7:0] last, logic [14:0] dv);
    write_reg(cvl_pkg::REG_TAPS_LOW, lo);
    write_reg(cvl_pkg::REG_TAP_LAST, {56'd0, last});
    write_reg(cvl_pkg::REG_DIVISOR, {49'd0, dv});
  endtask

  task automatic set_geometry(logic [11:0] w, logic [11:0] h);
    write_reg(cvl_pkg::REG_WIDTH, {52'd0, w});
    write_reg(cvl_pkg::REG_HEIGHT, {52'd0, h});
  endtask

  task automatic test_extreme_kernels;
    drain();
    set_geometry(12'd3, 12'd3);
    set_kernel({8{8'h80}}, 8'h7f, 15'd1);
    for (int i = 0; i < 9; i++) send_pixel(8'hff, i == 0);
    drain();
    set_kernel({8{8'h7f}}, 8'h7f, 15'd32767);
    for (int i = 0; i < 9; i++) send_pixel((i % 2) ? 8'h00 : 8'hff, i == 0);
  endtask

  task automatic test_out_of_range_registers;
    drain();
    set_geometry(12'd1, 12'd0);
    set_kernel(64'h0102_0304_0506_0708, 8'hff, 15'd0);
    for (int i = 0; i < 12; i++) send_pixel(8'($urandom_range(255)), i == 0);
  endtask

  task automatic test_shrink_midframe;
    drain();
    set_geometry(12'd8, 12'd8);
    set_kernel(64'h0101_0101_0101_0101, 8'h01, 15'd9);
    for (int i = 0; i < 21; i++) send_pixel(8'($urandom_range(255)), i == 0);
    drain();
    set_geometry(12'd4, 12'd3);
    for (int i = 0; i < 14; i++) send_pixel(8'($urandom_range(255)), 1'b0);
  endtask

  task automatic test_widest_line;
    drain();
    set_geometry(12'd64, 12'd4095);
    set_kernel(64'hff01_02fe_0403_fd05, 8'h06, 15'd3);
    no_idle = 1'b1;
    for (int i = 0; i < 2 * 64 + 8; i++) send_pixel(8'($urandom_range(255)), i == 0);
    no_idle = 1'b0;
  endtask

  task automatic test_random_frames;
    int unsigned target;
    int unsigned w;
    int unsigned h;
    int unsigned n;
    int unsigned phase;
    logic [63:0] lo;
    target = pixels_sent + 250;
    phase = 0;
    while (pixels_sent < target) begin
      drain();
      w = $urandom_range(3, 12);
      h = $urandom_range(3, 8);
      set_geometry(12'(w), 12'(h));
      if ($urandom_range(1)) lo = {$urandom, $urandom};
      else for (int b = 0; b < 8; b++) lo[8*b +: 8] = 8'($urandom_range(15));
      set_kernel(lo, 8'($urandom_range(255)),
                 ($urandom_range(3) == 0) ? 15'($urandom_range(1, 32767))
                                          : 15'($urandom_range(1, 60)));
      no_idle = (phase == 2);
      n = w * h * $urandom_range(1, 3) + $urandom_range(0, w);
      for (int i = 0; i < n && pixels_sent < target; i++)
        send_pixel(8'($urandom_range(255)), i == 0 || $urandom_range(99) < 2);
      phase++;
    end
    no_idle = 1'b0;
  endtask

  always @(negedge clk_i)
    out_ch.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 23);

  always @(posedge clk_i) begin
    grey_pixel_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t unexpected pixel argb %h row %0d col %0d", $time,
                 out_ch.pixel_argb, out_ch.out_row, out_ch.out_col);
        errors++;
      end else begin
        want = pending_pixels.pop_front();
        if (out_ch.pixel_argb !== want.argb) begin
          $display("%0t argb expected %h actual %h", $time, want.argb, out_ch.pixel_argb);
          errors++;
        end
        if (out_ch.out_row !== want.row) begin
          $display("%0t row expected %0d actual %0d", $time, want.row, out_ch.out_row);
          errors++;
        end
        if (out_ch.out_col !== want.col) begin
          $display("%0t col expected %0d actual %0d", $time, want.col, out_ch.out_col);
          errors++;
        end
        if (out_ch.frame_last !== want.last) begin
          $display("%0t frame_last expected %0b actual %0b", $time, want.last,
                   out_ch.frame_last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_extreme_kernels();
    test_out_of_range_registers();
    test_shrink_midframe();
    test_widest_line();
    test_random_frames();
    drain();
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
